// ----- rtl/core/npcq_pkg.sv -----
// Shared types, constants and the distance function of the palette quantizer.
package npcq_pkg;

    localparam int CH_W   = 8;
    localparam int SLOT_W = 8;
    localparam int DIST_W = 18;

    typedef enum logic {
        OP_PAL_WRITE = 1'b0,
        OP_PIXEL     = 1'b1
    } t_op;

    typedef enum logic {
        CFG_TRANSPARENT_INDEX = 1'b0,
        CFG_ALPHA_CUTOFF      = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic              transp;
        logic [DIST_W-1:0] best;
        logic [SLOT_W-1:0] best_idx;
        logic [DIST_W-1:0] cur_dist;
    } t_stage;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    function automatic logic [DIST_W-1:0] sq_dist(
        input logic [CH_W-1:0] r, input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
        input logic [3*CH_W-1:0] e);
        logic [CH_W-1:0]   dr, dg, db;
        logic [2*CH_W-1:0] sr, sg, sb;
        dr = (r > e[23:16]) ? r - e[23:16] : e[23:16] - r;
        dg = (g > e[15:8])  ? g - e[15:8]  : e[15:8]  - g;
        db = (b > e[7:0])   ? b - e[7:0]   : e[7:0]   - b;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    endfunction

endpackage

// ----- rtl/core/nearest_palette_color_quantizer_unit.sv -----
// Top level of the nearest-color palette quantizer: one cell per palette entry.
//
// One item enters per clock unless the output stalls. The pipeline holds
// one cell per palette entry: cell k keeps entry k in its own register,
// computes the squared RGB distance of the passing pixel to that entry, and
// the next cell folds it into the running minimum (strict less-than, so the
// lowest index wins on a tie; the transparent slot is skipped). Palette
// writes travel down the same pipeline and update cell k as they pass it,
// so every pixel sees exactly the writes accepted before it. Writes give no
// result. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Configuration writes are always ready and must only be issued while the
// block is empty.
module nearest_palette_color_quantizer_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // entry_slot, red, green, blue, alpha
    input  logic        i_s_tuser,  // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // color_slot
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int N = PALETTE_ENTRIES;

    logic [npcq_pkg::SLOT_W-1:0] r_trans;
    logic [npcq_pkg::CH_W-1:0]   r_cutoff;
    logic [3*npcq_pkg::CH_W-1:0] r_pal [N];
    npcq_pkg::t_stage            r_stg [N];
    npcq_pkg::t_stage            n_stg [N];
    npcq_pkg::t_stage            n_src [N];
    logic                        r_out_valid;
    logic                        r_out_transp;
    logic [npcq_pkg::SLOT_W-1:0] r_out_slot;
    logic                        adv;

    // Advance the whole pipeline unless a result is stuck at the output.
    assign adv         = !r_out_valid || i_m_tready;
    assign o_s_tready  = adv;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans  <= '0;
            r_cutoff <= '0;
        end else if (i_cfg_valid) begin
            unique case (npcq_pkg::t_cfg_idx'(i_cfg_index))
                npcq_pkg::CFG_TRANSPARENT_INDEX: r_trans  <= i_cfg_data;
                npcq_pkg::CFG_ALPHA_CUTOFF:      r_cutoff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input item as seen by cell 0.
    always_comb begin
        n_src[0]          = '0;
        n_src[0].valid    = i_s_tvalid;
        n_src[0].op       = npcq_pkg::t_op'(i_s_tuser);
        n_src[0].slot     = i_s_tdata[7:0];
        n_src[0].red      = i_s_tdata[15:8];
        n_src[0].green    = i_s_tdata[23:16];
        n_src[0].blue     = i_s_tdata[31:24];
        n_src[0].transp   = i_s_tdata[39:32] < r_cutoff;
        n_src[0].best     = npcq_pkg::DIST_MAX;
        n_src[0].best_idx = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        if (k > 0) begin : g_fold
            // Fold entry k-1 into the running minimum.
            always_comb begin
                n_src[k] = r_stg[k-1];
                if (r_trans != npcq_pkg::SLOT_W'(k-1) &&
                    r_stg[k-1].cur_dist < r_stg[k-1].best) begin
                    n_src[k].best     = r_stg[k-1].cur_dist;
                    n_src[k].best_idx = npcq_pkg::SLOT_W'(k-1);
                end
            end
        end

        always_comb begin
            n_stg[k]          = n_src[k];
            n_stg[k].cur_dist = npcq_pkg::sq_dist(n_src[k].red, n_src[k].green,
                                                  n_src[k].blue, r_pal[k]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k].valid <= 1'b0;
            end else if (adv) begin
                r_stg[k] <= n_stg[k];
            end
        end

        // Load the entry as a write item passes into this cell.
        always_ff @(posedge i_clk) begin
            if (adv && n_src[k].valid && n_src[k].op == npcq_pkg::OP_PAL_WRITE &&
                n_src[k].slot == npcq_pkg::SLOT_W'(k)) begin
                r_pal[k] <= {n_src[k].red, n_src[k].green, n_src[k].blue};
            end
        end
    end

    // Output register: last fold, transparent override; drop write items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_stg[N-1].valid && r_stg[N-1].op == npcq_pkg::OP_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_transp <= r_stg[N-1].transp;
            priority if (r_stg[N-1].transp) begin
                r_out_slot <= r_trans;
            end else if (r_trans != npcq_pkg::SLOT_W'(N-1) &&
                         r_stg[N-1].cur_dist < r_stg[N-1].best) begin
                r_out_slot <= npcq_pkg::SLOT_W'(N-1);
            end else begin
                r_out_slot <= r_stg[N-1].best_idx;
            end
        end
    end

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while output stalled");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_stg[N-1].valid) && $stable(r_stg[N-1].best_idx))
        else $error("pipeline tail moved during stall");

    a_skip_transparent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_transp && {1'b0, r_trans} < 9'(N) |-> o_m_tdata != r_trans)
        else $error("search returned the transparent slot");

endmodule

// ----- tb/nearest_palette_color_quantizer_unit_tb.sv -----
// Testbench for the palette quantizer: random palettes, pixels and register settings.
module nearest_palette_color_quantizer_unit_tb;

    // Scoreboard: own palette copy, register copy and queue of expected slots.
    class slot_scoreboard;
        logic [23:0] palette [256];
        logic [7:0]  transp_slot;
        logic [7:0]  cutoff;
        logic [7:0]  pending_slots [$];
        int          n_errors;

        function new();
            transp_slot = 8'd0;
            cutoff      = 8'd0;
            n_errors    = 0;
        endfunction

        function logic [7:0] nearest(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int best;
            int idx;
            int d;
            int dr, dg, db;
            best = 32'h7fffffff;
            idx  = 0;
            for (int c = 0; c < 256; c++) begin
                if (c == int'(transp_slot)) continue;
                dr = int'(r) - int'(palette[c][23:16]);
                dg = int'(g) - int'(palette[c][15:8]);
                db = int'(b) - int'(palette[c][7:0]);
                d  = dr * dr + dg * dg + db * db;
                if (d < best) begin
                    best = d;
                    idx  = c;
                end
            end
            return idx[7:0];
        endfunction

        // Note one accepted input item.
        function void note_item(npcq_pkg::t_op op, logic [7:0] slot, logic [7:0] r,
                                logic [7:0] g, logic [7:0] b, logic [7:0] a);
            if (op == npcq_pkg::OP_PAL_WRITE) begin
                palette[slot] = {r, g, b};
            end else if (a < cutoff) begin
                pending_slots = {pending_slots, transp_slot};
            end else begin
                pending_slots = {pending_slots, nearest(r, g, b)};
            end
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_slot(logic [7:0] got);
            logic [7:0] want;
            if (pending_slots.size() == 0) begin
                $error("color_slot: no result expected, got %0d", got);
                n_errors++;
                return;
            end
            want = pending_slots.pop_front();
            if (got !== want) begin
                $error("color_slot: expected %0d, got %0d", want, got);
                n_errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;  // entry_slot, red, green, blue, alpha
    logic        i_s_tuser;  // op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;  // color_slot
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    slot_scoreboard sb;
    bit             calm;     // no idling on either side
    bit             rx_stall; // receiver allowed to stall

    nearest_palette_color_quantizer_unit u_top (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Sample results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_slot(o_m_tdata);
    end

    // Receiver: random stall bursts unless calm.
    initial begin
        int n;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && rx_stall && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                i_m_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // Send one item; optional sender gap first. Called at a falling edge.
    task automatic send_item(npcq_pkg::t_op op, logic [7:0] slot, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b, logic [7:0] a);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 11);
            i_s_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {a, b, g, r, slot};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(op, slot, r, g, b, a);
        @(negedge i_clk);
    endtask

    task automatic rand_pixel();
        send_item(npcq_pkg::OP_PIXEL, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                  8'($urandom()), 8'($urandom()));
    endtask

    // Hold off until all results are back, then let the pipeline drain.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending_slots.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Write one register while the block is empty.
    task automatic write_reg(npcq_pkg::t_cfg_idx idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == npcq_pkg::CFG_TRANSPARENT_INDEX) sb.transp_slot = val;
        else sb.cutoff = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_palette();
        for (int c = 0; c < 256; c++)
            send_item(npcq_pkg::OP_PAL_WRITE, 8'(c), 8'($urandom()), 8'($urandom()),
                      8'($urandom()), 8'($urandom()));
    endtask

    initial begin
        sb          = new();
        calm        = 1'b0;
        rx_stall    = 1'b1;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = npcq_pkg::OP_PAL_WRITE;
        i_cfg_valid = 1'b0;
        i_cfg_index = npcq_pkg::CFG_TRANSPARENT_INDEX;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill every entry before the first pixel.
        load_palette();
        // Directed: channel extremes, exact hits, ties, alpha edges.
        send_item(npcq_pkg::OP_PAL_WRITE, 8'd10, 8'h00, 8'h00, 8'h00, 8'hff);
        send_item(npcq_pkg::OP_PAL_WRITE, 8'd20, 8'h00, 8'h00, 8'h00, 8'h00);  // tie with 10
        send_item(npcq_pkg::OP_PAL_WRITE, 8'd255, 8'hff, 8'hff, 8'hff, 8'h00);
        send_item(npcq_pkg::OP_PAL_WRITE, 8'd0, 8'h80, 8'h80, 8'h80, 8'h00);
        send_item(npcq_pkg::OP_PIXEL, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);  // zero cutoff
        send_item(npcq_pkg::OP_PIXEL, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(npcq_pkg::OP_PIXEL, 8'h00, 8'h80, 8'h80, 8'h80, 8'hff);  // slot 0 skipped
        send_item(npcq_pkg::OP_PIXEL, 8'h55, 8'hff, 8'h00, 8'hff, 8'h80);
        send_item(npcq_pkg::OP_PIXEL, 8'haa, 8'h00, 8'hff, 8'h00, 8'h01);
        drain();
        write_reg(npcq_pkg::CFG_TRANSPARENT_INDEX, 8'd255);
        write_reg(npcq_pkg::CFG_ALPHA_CUTOFF, 8'd255);
        send_item(npcq_pkg::OP_PIXEL, 8'h00, 8'hff, 8'hff, 8'hff, 8'hfe);  // transparent
        send_item(npcq_pkg::OP_PIXEL, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);  // 255 skipped
        send_item(npcq_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcq_pkg::OP_PIXEL, 8'h00, 8'h80, 8'h80, 8'h80, 8'hff);  // slot 0 found
        drain();

        // Random phases: several register settings, mixed writes and pixels.
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(npcq_pkg::CFG_TRANSPARENT_INDEX, ph == 0 ? 8'd0 : 8'($urandom()));
            write_reg(npcq_pkg::CFG_ALPHA_CUTOFF,
                      ph == 1 ? 8'd0 : ph == 2 ? 8'd1 : 8'($urandom()));
            if (ph == 4) calm = 1'b1;
            for (int k = 0; k < 320; k++) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(npcq_pkg::OP_PAL_WRITE, 8'($urandom()), 8'($urandom()),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
                else
                    rand_pixel();
            end
            drain();
        end

        while (sb.pending_slots.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
        if (sb.n_errors == 0 && sb.pending_slots.size() == 0)
            $display("nearest_palette_color_quantizer_unit test passed");
        else
            $display("nearest_palette_color_quantizer_unit test failed");
        $finish;
    end

    // Watchdog: well above the slowest legal run.
    initial begin
        #20000000;
        $display("nearest_palette_color_quantizer_unit test failed");
        $finish;
    end

endmodule

// ----- nearest_palette_color_quantizer_unit.f -----
rtl/core/npcq_pkg.sv
rtl/core/nearest_palette_color_quantizer_unit.sv
tb/nearest_palette_color_quantizer_unit_tb.sv
